>>> src/cqe_pkg.sv
// ----------------------------------------------------------------------------
// cqe_pkg: shared types and codes of the circular queue engine
// Request kinds, result status codes and the result descriptor that the
// controller hands to the output buffer.
// ----------------------------------------------------------------------------
package cqe_pkg;

	// Fixed field widths
	localparam int CFG_W = 7;
	localparam int REQ_W = 2;
	localparam int ST_W  = 2;

	// Request kinds
	localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;
	localparam logic [REQ_W-1:0] REQ_SHOW = 2'd3;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

	// Result descriptor: data comes from the store read when use_rd is set
	typedef struct packed {
		logic [ST_W-1:0] status;
		logic            last;
		logic            use_rd;
	} res_t;

endpackage

>>> src/circular_queue_engine_top.sv
// ----------------------------------------------------------------------------
// circular_queue_engine_top: circular FIFO engine with a settable slot count
// A result is registered beside its store read, then held in a two-entry
// output buffer. Enqueue, dequeue and peek give one result each; show gives
// one per stored entry (at least one), paced by the single store read port.
// Reset: asynchronous, clears head, tail and occupancy and sets the slot count
// to DEPTH; the slot store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module circular_queue_engine_top
	import cqe_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 31,
	localparam int TDATA_W    = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,  // queue_size
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,    // item_value, zero fill above
	input  logic [REQ_W-1:0]   s_tuser,    // req_type
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,    // data_out, zero fill above
	output logic [ST_W-1:0]    m_tuser,    // status
	output logic               m_tlast
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                   space;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [VALUE_WIDTH-1:0] mem_wdata;
	logic                   mem_re;
	logic [IDX_W-1:0]       mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_rdata;
	logic                   issue;
	res_t                   issue_res;

	cqe_ctrl #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.req_type   (s_tuser),
		.item_value (s_tdata[VALUE_WIDTH-1:0]),
		.space      (space),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.issue      (issue),
		.issue_res  (issue_res)
	);

	cqe_mem #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.IDX_W       (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cqe_obuf #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.TDATA_W     (TDATA_W)
	) u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.issue_res (issue_res),
		.rd_data   (mem_rdata),
		.space     (space),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

>>> src/cqe_mem.sv
// ----------------------------------------------------------------------------
// cqe_mem: slot storage of the circular queue engine
// One write port and one read port; read data is registered, so it shows
// in the cycle after the read request.
// ----------------------------------------------------------------------------
module cqe_mem #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 31,
	parameter int IDX_W       = 6
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [IDX_W-1:0]       waddr,
	input  logic [VALUE_WIDTH-1:0] wdata,
	input  logic                   re,
	input  logic [IDX_W-1:0]       raddr,
	output logic [VALUE_WIDTH-1:0] rdata
);

	logic [VALUE_WIDTH-1:0] slot_mem [DEPTH];
	logic [VALUE_WIDTH-1:0] rdata_q;

	// Write the tail slot, register the read slot
	always_ff @(posedge clk) begin
		if (we) begin
			slot_mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= slot_mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/cqe_ctrl.sv
// ----------------------------------------------------------------------------
// cqe_ctrl: pointer and sequencing logic of the circular queue engine
// Holds head, tail, occupancy and the slot count in use, decodes each
// request, drives the store ports and walks the queue for a show request.
// ----------------------------------------------------------------------------
module cqe_ctrl
	import cqe_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 31,
	parameter int IDX_W       = 6,
	parameter int CNT_W       = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [REQ_W-1:0]       req_type,
	input  logic [VALUE_WIDTH-1:0] item_value,
	input  logic                   space,
	output logic                   mem_we,
	output logic [IDX_W-1:0]       mem_waddr,
	output logic [VALUE_WIDTH-1:0] mem_wdata,
	output logic                   mem_re,
	output logic [IDX_W-1:0]       mem_raddr,
	output logic                   issue,
	output res_t                   issue_res
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SHOW = 1'b1;

	logic             state_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] active_q;
	logic [IDX_W-1:0] walk_idx_q;
	logic [CNT_W-1:0] remain_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic [CNT_W-1:0] cfg_active;

	// Step an index around the ring of slots in use
	function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] act);
		logic [IDX_W:0] nxt;
		nxt = {1'b0, idx} + (IDX_W+1)'(1);
		if (8'(nxt) >= 8'(act)) begin
			return '0;
		end
		return nxt[IDX_W-1:0];
	endfunction

	assign s_tready = (state_q == S_IDLE) && space;
	assign accept   = s_tvalid && s_tready;
	assign full     = (occ_q >= active_q);
	assign empty    = (occ_q == '0);

	assign mem_waddr = tail_q;
	assign mem_wdata = item_value;

	// Clamp the written slot count into 1..DEPTH
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_active = CNT_W'(1);
		end else if (cfg_wdata > CFG_W'(DEPTH)) begin
			cfg_active = CNT_W'(DEPTH);
		end else begin
			cfg_active = cfg_wdata[CNT_W-1:0];
		end
	end

	// Decode the request, or the next show walk step, into store accesses and one result descriptor
	always_comb begin
		mem_we           = 1'b0;
		mem_re           = 1'b0;
		mem_raddr        = head_q;
		issue            = 1'b0;
		issue_res.status = ST_OK;
		issue_res.last   = 1'b1;
		issue_res.use_rd = 1'b0;
		if (state_q == S_SHOW) begin
			if (space) begin
				issue            = 1'b1;
				mem_re           = 1'b1;
				mem_raddr        = walk_idx_q;
				issue_res.use_rd = 1'b1;
				issue_res.last   = (remain_q == CNT_W'(1));
			end
		end else if (accept) begin
			issue = 1'b1;
			case (req_type) inside
				REQ_ENQ: begin
					if (full) begin
						issue_res.status = ST_OVERFLOW;
					end else begin
						mem_we = 1'b1;
					end
				end
				REQ_DEQ, REQ_PEEK, REQ_SHOW: begin
					if (empty) begin
						issue_res.status = ST_EMPTY;
					end else begin
						mem_re           = 1'b1;
						issue_res.use_rd = 1'b1;
						if (req_type == REQ_SHOW) begin
							issue_res.last = (occ_q == CNT_W'(1));
						end
					end
				end
				default: begin
					issue_res.status = ST_OK;
				end
			endcase
		end
	end

	// Update pointers, occupancy, the slot count and the show walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			occ_q      <= '0;
			active_q   <= CNT_W'(DEPTH);
			walk_idx_q <= '0;
			remain_q   <= '0;
		end else if (cfg_we) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			occ_q    <= '0;
			active_q <= cfg_active;
		end else if (state_q == S_SHOW) begin
			if (space) begin
				walk_idx_q <= adv(walk_idx_q, active_q);
				remain_q   <= remain_q - CNT_W'(1);
				if (remain_q == CNT_W'(1)) begin
					state_q <= S_IDLE;
				end
			end
		end else if (accept) begin
			case (req_type) inside
				REQ_ENQ: begin
					if (!full) begin
						tail_q <= adv(tail_q, active_q);
						occ_q  <= occ_q + CNT_W'(1);
					end
				end
				REQ_DEQ: begin
					if (!empty) begin
						head_q <= adv(head_q, active_q);
						occ_q  <= occ_q - CNT_W'(1);
					end
				end
				REQ_SHOW: begin
					if (!empty && occ_q != CNT_W'(1)) begin
						state_q    <= S_SHOW;
						walk_idx_q <= adv(head_q, active_q);
						remain_q   <= occ_q - CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= active_q)
		else $error("occupancy above slot count");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(8'(head_q) < 8'(active_q)) && (8'(tail_q) < 8'(active_q)))
		else $error("queue pointer outside slots in use");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHOW) |-> (remain_q != '0) && (remain_q < occ_q))
		else $error("show walk count out of range");
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store read and write in the same cycle");
`endif

endmodule

>>> src/cqe_obuf.sv
// ----------------------------------------------------------------------------
// cqe_obuf: result stage and output buffer of the circular queue engine
// Registers the result descriptor alongside the store read, merges the read
// data and queues results in a two-entry buffer toward the output stream.
// ----------------------------------------------------------------------------
module cqe_obuf
	import cqe_pkg::*;
#(
	parameter int VALUE_WIDTH = 31,
	parameter int TDATA_W     = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   issue,
	input  res_t                   issue_res,
	input  logic [VALUE_WIDTH-1:0] rd_data,
	output logic                   space,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_W-1:0]     m_tdata,
	output logic [ST_W-1:0]        m_tuser,
	output logic                   m_tlast
);

	logic                   v_s1;
	res_t                   res_s1;
	logic [1:0]             cnt_q;
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [ST_W-1:0]        ent_status_q [2];
	logic                   ent_last_q   [2];
	logic [VALUE_WIDTH-1:0] ent_data_q   [2];

	logic                   push;
	logic                   pop;
	logic [VALUE_WIDTH-1:0] push_data;

	assign push      = v_s1;
	assign pop       = m_tvalid && m_tready;
	assign push_data = res_s1.use_rd ? rd_data : '0;

	// Grant a new request only if its result finds a free entry
	assign space = (({1'b0, cnt_q} + 3'(v_s1) - 3'(pop)) < 3'd2);

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = TDATA_W'(ent_data_q[rd_ptr_q]);
	assign m_tuser  = ent_status_q[rd_ptr_q];
	assign m_tlast  = ent_last_q[rd_ptr_q];

	// Track the request in flight through the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= issue_res;
	end

	// Advance buffer pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Hold the merged result in the buffer
	always_ff @(posedge clk) begin
		if (push) begin
			ent_status_q[wr_ptr_q] <= res_s1.status;
			ent_last_q[wr_ptr_q]   <= res_s1.last;
			ent_data_q[wr_ptr_q]   <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("output buffer count above two");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (cnt_q < 2'd2))
		else $error("result pushed into a full output buffer");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
		else $error("output buffer pointers disagree with count");
`endif

endmodule

>>> dv/circular_queue_engine_top_tb.sv
// ----------------------------------------------------------------------------
// circular_queue_engine_top_tb: self-checking bench for the circular queue
// Drives enqueue, dequeue, peek and show requests in random bursts under
// several slot counts, predicts every result in a scoreboard class and
// checks each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module circular_queue_engine_top_tb;
	import cqe_pkg::*;

	localparam int DEPTH        = 64;
	localparam int VW           = 31;
	localparam int DW           = 32;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 51;
	localparam longint LIMIT_CYCLES = 3000000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [DW-1:0]      s_tdata;
	logic [REQ_W-1:0]   s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [DW-1:0]      m_tdata;
	logic [ST_W-1:0]    m_tuser;
	logic               m_tlast;

	// set once by the stimulus, cleared by the receiver when it starts holding off
	bit hold_off_pending = 1'b0;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic [VW-1:0]   data;
		logic            last;
	} queue_result_t;

	// Ring buffer predictor plus the store of results still to arrive
	class queue_scoreboard;
		logic [VW-1:0]   slots [DEPTH];
		int              head;
		int              tail;
		int              fill;
		logic [CFG_W-1:0] size_setting;
		queue_result_t   pending_results [$];
		int              errors;

		function new();
			head = 0;
			tail = 0;
			fill = 0;
			size_setting = CFG_W'(DEPTH);
			errors = 0;
		endfunction

		function int active_slots();
			if (size_setting == 0)
				return 1;
			if (size_setting > DEPTH)
				return DEPTH;
			return int'(size_setting);
		endfunction

		function int next_slot(int idx);
			return (idx + 1 >= active_slots()) ? 0 : idx + 1;
		endfunction

		function void push(logic [ST_W-1:0] st, logic [VW-1:0] data, logic lst);
			queue_result_t r;
			r.status = st;
			r.data   = data;
			r.last   = lst;
			pending_results.push_back(r);
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// A size write empties the queue; stored values become unreachable
		function void apply_size(logic [CFG_W-1:0] v);
			size_setting = v;
			head = 0;
			tail = 0;
			fill = 0;
		endfunction

		// Advance the model by one accepted request and queue its results
		function void note_request(logic [REQ_W-1:0] op, logic [VW-1:0] val);
			int idx;
			int k;
			if (op == REQ_ENQ) begin
				if (fill >= active_slots()) begin
					push(ST_OVERFLOW, '0, 1'b1);
				end else begin
					slots[tail] = val;
					tail = next_slot(tail);
					fill++;
					push(ST_OK, '0, 1'b1);
				end
			end else if (fill == 0) begin
				push(ST_EMPTY, '0, 1'b1);
			end else if (op == REQ_DEQ) begin
				push(ST_OK, slots[head], 1'b1);
				head = next_slot(head);
				fill--;
			end else if (op == REQ_PEEK) begin
				push(ST_OK, slots[head], 1'b1);
			end else begin
				// walk head to tail across the wrap
				idx = head;
				for (k = 0; k < fill; k++) begin
					push(ST_OK, slots[idx], k == fill - 1);
					idx = next_slot(idx);
				end
			end
		endfunction

		function void check_result(logic [ST_W-1:0] st, logic [DW-1:0] data, logic lst);
			queue_result_t exp_r;
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d data 0x%0h last %0d", st, data, lst);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (st !== exp_r.status) begin
				$error("status mismatch: expected %0d, actual %0d", exp_r.status, st);
				errors++;
			end
			if (data !== {1'b0, exp_r.data}) begin
				$error("data_out mismatch: expected 0x%0h, actual 0x%0h", exp_r.data, data);
				errors++;
			end
			if (lst !== exp_r.last) begin
				$error("last mismatch: expected %0d, actual %0d", exp_r.last, lst);
				errors++;
			end
		endfunction
	endclass

	queue_scoreboard sb = new();

	circular_queue_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#(LIMIT_CYCLES * 8);
		$display("circular_queue_engine_top verification failed");
		$finish;
	end

	// Check every result taken by the receiver
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata, m_tlast);
	end

	// Receiver: stall pattern of its own, plus one long hold-off on request
	initial begin
		int span;
		int mode;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(10, 120);
				repeat (span) begin
					if (hold_off_pending)
						break;
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) == 0);
						default: m_tready <= ($urandom_range(0, 7) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Offer one request and hold it until accepted; leaves tvalid high
	task automatic send_request(input logic [REQ_W-1:0] op, input logic [VW-1:0] val);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, val};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(op, val);
	endtask

	// Drain all results, let the pipe settle, then write the slot count
	task automatic set_queue_size(input logic [CFG_W-1:0] v);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		sb.apply_size(v);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [VW-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r == 2)
			return VW'($urandom_range(1, 255));
		return VW'($urandom());
	endfunction

	// Random requests in bursts with random gaps; enq_pct biases toward filling
	task automatic run_phase(input int items, input int enq_pct);
		int i;
		int r;
		int burst;
		logic [REQ_W-1:0] op;
		burst = $urandom_range(1, 24);
		for (i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			if (r < enq_pct)
				op = REQ_ENQ;
			else if (r < enq_pct + 8)
				op = REQ_SHOW;
			else if (r < enq_pct + 20)
				op = REQ_PEEK;
			else
				op = REQ_DEQ;
			send_request(op, pick_value());
			burst--;
			if (burst == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst = $urandom_range(1, 24);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// Stimulus
	initial begin
		int p;
		int size_plan [8];
		int enq_plan  [8];
		size_plan = '{3, 127, 1, 17, 64, 0, -1, -1};
		enq_plan  = '{50, 80, 45, 60, 75, 50, -1, -1};
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= REQ_ENQ;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, value extremes, show with several entries, drain to empty
		send_request(REQ_PEEK, '1);
		send_request(REQ_DEQ, '1);
		send_request(REQ_SHOW, '0);
		send_request(REQ_ENQ, '0);
		send_request(REQ_ENQ, '1);
		send_request(REQ_ENQ, 31'h2AAA_AAAA);
		send_request(REQ_PEEK, '0);
		send_request(REQ_SHOW, 31'h5555_5555);
		send_request(REQ_DEQ, '0);
		send_request(REQ_DEQ, '0);
		send_request(REQ_DEQ, '0);
		send_request(REQ_DEQ, '0);
		s_tvalid <= 1'b0;

		// one slot: overflow on the second enqueue
		set_queue_size(7'd1);
		send_request(REQ_ENQ, 31'h5555_5555);
		send_request(REQ_ENQ, 31'h1234_5678);
		send_request(REQ_PEEK, '0);
		send_request(REQ_SHOW, '0);
		send_request(REQ_DEQ, '0);
		s_tvalid <= 1'b0;

		// zero acts as one slot
		set_queue_size(7'd0);
		send_request(REQ_ENQ, 31'h7F00_00FF);
		send_request(REQ_ENQ, '1);
		send_request(REQ_SHOW, '0);
		s_tvalid <= 1'b0;

		// random phases over several slot counts
		for (p = 0; p < 8; p++) begin
			set_queue_size(size_plan[p] < 0 ? CFG_W'($urandom_range(0, 127))
				: CFG_W'(size_plan[p]));
			if (size_plan[p] == 127)
				hold_off_pending = 1'b1;
			run_phase(PHASE_ITEMS, enq_plan[p] < 0 ? $urandom_range(35, 70) : enq_plan[p]);
		end

		// wait out the remaining results
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES * 2) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("circular_queue_engine_top verification clean");
		else
			$display("circular_queue_engine_top verification failed");
		$finish;
	end

endmodule

>>> sim.f
src/cqe_pkg.sv
src/cqe_mem.sv
src/cqe_ctrl.sv
src/cqe_obuf.sv
src/circular_queue_engine_top.sv
dv/circular_queue_engine_top_tb.sv
